FILE: hw/rtl/word_token_classifier_defines.svh
// Assertion macros shared by the word token classifier modules.
`ifndef WORD_TOKEN_CLASSIFIER_DEFINES_SVH
`define WORD_TOKEN_CLASSIFIER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define WTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define WTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define WTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WTC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/wtc_pkg.sv
// Shared types, keyword tables and helper functions of the word token classifier.
package wtc_pkg;

    localparam int NUM_KW     = 16;
    localparam int KW_SLOTS   = 8;
    localparam int KW_MAXLEN  = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW   = 2;

    typedef enum logic [3:0] {
        TC_TYPE       = 4'd0,
        TC_LOGICAL    = 4'd1,
        TC_COMPARISON = 4'd2,
        TC_IF         = 4'd3,
        TC_ELSE       = 4'd4,
        TC_NUMBER     = 4'd5,
        TC_IDENT      = 4'd6,
        TC_LITERAL    = 4'd7,
        TC_UNKNOWN    = 4'd8
    } t_token_class;

    typedef enum logic [3:0] {
        NS_START   = 4'd0,
        NS_MINUS   = 4'd1,
        NS_INT     = 4'd2,
        NS_DOT     = 4'd3,
        NS_FRAC    = 4'd4,
        NS_EXP     = 4'd5,
        NS_EXPSIGN = 4'd6,
        NS_EXPDIG  = 4'd7,
        NS_DEAD    = 4'd8
    } t_num_state;

    // What the front learned about one finished word.
    typedef struct packed {
        logic [NUM_KW-1:0] kw_hit;
        logic              num_ok;
        logic [7:0]        first_byte;
        logic [7:0]        last_byte;
        logic [15:0]       length;
    } t_word_summary;

    // Keyword spellings, zero padded to eight slots.
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // int
        '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00}, // float
        '{8'h64, 8'h6F, 8'h75, 8'h62, 8'h6C, 8'h65, 8'h00, 8'h00}, // double
        '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00}, // char
        '{8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67, 8'h00, 8'h00}, // string
        '{8'h62, 8'h6F, 8'h6F, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00}, // bool
        '{8'h26, 8'h26, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // &&
        '{8'h7C, 8'h7C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // ||
        '{8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // <
        '{8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // >
        '{8'h3C, 8'h3D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // <=
        '{8'h3E, 8'h3D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // >=
        '{8'h3D, 8'h3D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // ==
        '{8'h21, 8'h3D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // !=
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // if
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}  // else
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd5, 3'd6, 3'd4, 3'd6, 3'd4, 3'd2, 3'd2,
        3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4
    };

    localparam t_token_class KW_CLASS [NUM_KW] = '{
        TC_TYPE, TC_TYPE, TC_TYPE, TC_TYPE, TC_TYPE, TC_TYPE,
        TC_LOGICAL, TC_LOGICAL,
        TC_COMPARISON, TC_COMPARISON, TC_COMPARISON,
        TC_COMPARISON, TC_COMPARISON, TC_COMPARISON,
        TC_IF, TC_ELSE
    };

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // One step of the signed decimal number recognizer.
    function automatic t_num_state num_next(input t_num_state s, input logic [7:0] b);
        logic       d;
        logic       e;
        t_num_state n;
        d = is_digit(b);
        e = (b == 8'h65) || (b == 8'h45);
        case (s)
            NS_START:   n = (b == 8'h2D) ? NS_MINUS : (d ? NS_INT : NS_DEAD);
            NS_MINUS:   n = d ? NS_INT : NS_DEAD;
            NS_INT:     n = d ? NS_INT : ((b == 8'h2E) ? NS_DOT : (e ? NS_EXP : NS_DEAD));
            NS_DOT:     n = d ? NS_FRAC : NS_DEAD;
            NS_FRAC:    n = d ? NS_FRAC : (e ? NS_EXP : NS_DEAD);
            NS_EXP:     n = (b == 8'h2B || b == 8'h2D) ? NS_EXPSIGN
                            : (d ? NS_EXPDIG : NS_DEAD);
            NS_EXPSIGN: n = d ? NS_EXPDIG : NS_DEAD;
            NS_EXPDIG:  n = d ? NS_EXPDIG : NS_DEAD;
            default:    n = NS_DEAD;
        endcase
        return n;
    endfunction

endpackage

FILE: hw/rtl/wtc_front.sv
// Front end: per-byte word tracking, keyword and number automata, word summaries.
`include "word_token_classifier_defines.svh"

module wtc_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_end_of_text,
    output logic                   o_push,
    output wtc_pkg::t_word_summary o_summary
);

    localparam int LW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    logic                         r_inside, n_inside;
    logic [LENGTH_BITS-1:0]       r_len, n_len;
    logic [wtc_pkg::NUM_KW-1:0]   r_kw, n_kw;
    wtc_pkg::t_num_state          r_num, n_num;
    logic [7:0]                   r_open, n_open;
    logic [7:0]                   r_close, n_close;

    logic           word_end;
    logic           len_small;
    logic [2:0]     idx;
    logic [LW-1:0]  len_ext;

    assign word_end  = i_end_of_text || wtc_pkg::is_space(i_text_byte);
    assign len_small = r_len < LENGTH_BITS'(wtc_pkg::KW_MAXLEN);
    assign idx       = r_len[2:0];
    assign len_ext   = LW'(r_len);

    assign o_push = i_accept && word_end && r_inside;

    always_comb begin
        for (int k = 0; k < wtc_pkg::NUM_KW; k++) begin
            o_summary.kw_hit[k] = r_kw[k] && (r_len == LENGTH_BITS'(wtc_pkg::KW_LEN[k]));
        end
        o_summary.num_ok = (r_num == wtc_pkg::NS_INT) || (r_num == wtc_pkg::NS_FRAC) ||
                           (r_num == wtc_pkg::NS_EXPDIG);
        o_summary.first_byte = r_open;
        o_summary.last_byte  = r_close;
        o_summary.length     = (len_ext > LW'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];
    end

    always_comb begin
        n_inside = r_inside;
        n_len    = r_len;
        n_kw     = r_kw;
        n_num    = r_num;
        n_open   = r_open;
        n_close  = r_close;
        if (i_accept) begin
            if (word_end) begin
                n_inside = 1'b0;
                n_len    = '0;
                n_kw     = '1;
                n_num    = wtc_pkg::NS_START;
                n_open   = 8'h00;
                n_close  = 8'h00;
            end else begin
                n_inside = 1'b1;
                n_open   = r_inside ? r_open : i_text_byte;
                n_close  = i_text_byte;
                for (int k = 0; k < wtc_pkg::NUM_KW; k++) begin
                    n_kw[k] = r_kw[k] && len_small && (idx < wtc_pkg::KW_LEN[k]) &&
                              (wtc_pkg::KW_TEXT[k][idx] == i_text_byte);
                end
                n_num = wtc_pkg::num_next(r_num, i_text_byte);
                if (r_len != '1) begin
                    n_len = r_len + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_len    <= '0;
            r_kw     <= '1;
            r_num    <= wtc_pkg::NS_START;
            r_open   <= 8'h00;
            r_close  <= 8'h00;
        end else begin
            r_inside <= n_inside;
            r_len    <= n_len;
            r_kw     <= n_kw;
            r_num    <= n_num;
            r_open   <= n_open;
            r_close  <= n_close;
        end
    end

    // A summary only leaves for a word that has at least one byte.
    `WTC_ASSERT_IMP(a_push_inside, i_clk, i_rst_n, o_push, r_inside && (r_len != '0))
    // A word byte always leaves the tracker inside a word.
    `WTC_ASSERT_NXT(a_byte_enters, i_clk, i_rst_n, i_accept && !word_end, r_inside)

endmodule

FILE: hw/rtl/wtc_fifo.sv
// Short queue of word summaries between the front and the back.
`include "word_token_classifier_defines.svh"

module wtc_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  wtc_pkg::t_word_summary i_data,
    output logic                   o_full,
    input  logic                   i_pop,
    output wtc_pkg::t_word_summary o_data,
    output logic                   o_empty
);

    localparam logic [wtc_pkg::QUEUE_AW:0] DEPTH =
        (wtc_pkg::QUEUE_AW + 1)'(wtc_pkg::QUEUE_DEPTH);

    wtc_pkg::t_word_summary         r_mem [wtc_pkg::QUEUE_DEPTH];
    logic [wtc_pkg::QUEUE_AW-1:0]   r_wr, n_wr;
    logic [wtc_pkg::QUEUE_AW-1:0]   r_rd, n_rd;
    logic [wtc_pkg::QUEUE_AW:0]     r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == DEPTH;
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `WTC_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH)
    // The front must never offer a summary while the queue is full.
    `WTC_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, o_full, !i_push)

endmodule

FILE: hw/rtl/wtc_back.sv
// Back end: priority classification of word summaries into a result register.
`include "word_token_classifier_defines.svh"

module wtc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wtc_pkg::t_word_summary i_summary,
    input  logic                   i_q_empty,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output wtc_pkg::t_token_class  o_token_class,
    output logic [15:0]            o_word_length
);

    logic                   r_valid, n_valid;
    wtc_pkg::t_token_class  r_class;
    logic [15:0]            r_len;

    wtc_pkg::t_token_class  cls;
    logic                   kw_any;
    logic                   take;
    logic [7:0]             f;

    assign f = i_summary.first_byte;

    always_comb begin
        cls    = wtc_pkg::TC_UNKNOWN;
        kw_any = |i_summary.kw_hit;
        if (i_summary.first_byte == 8'h22 && i_summary.last_byte == 8'h22) begin
            cls = wtc_pkg::TC_LITERAL;
        end
        if ((f >= 8'h41 && f <= 8'h5A) || (f >= 8'h61 && f <= 8'h7A) || f == 8'h5F) begin
            cls = wtc_pkg::TC_IDENT;
        end
        if (i_summary.num_ok) begin
            cls = wtc_pkg::TC_NUMBER;
        end
        // Lowest keyword index wins, so scan from the top down.
        if (kw_any) begin
            for (int k = wtc_pkg::NUM_KW - 1; k >= 0; k--) begin
                if (i_summary.kw_hit[k]) begin
                    cls = wtc_pkg::KW_CLASS[k];
                end
            end
        end
    end

    assign take    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = take;
    assign n_valid = take ? 1'b1 : (i_pop ? 1'b0 : r_valid);

    assign o_empty       = !r_valid;
    assign o_token_class = r_class;
    assign o_word_length = r_len;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_class <= cls;
            r_len   <= i_summary.length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // A waiting summary always fills an empty result register by the next edge.
    `WTC_ASSERT_NXT(a_fill_output, i_clk, i_rst_n, !i_q_empty && !r_valid, r_valid)

endmodule

FILE: hw/rtl/word_token_classifier.sv
// Top level of the word token classifier: front, summary queue and back.
//
//  channel   direction  handshake            payload
//  -------   ---------  ---------            -------
//  text      in         push / full          i_text_byte, i_end_of_text
//  result    out        empty / pop          o_token_class, o_word_length
//
// One text beat is taken in every cycle in which push is high and full is low; the automata
// advance a byte a cycle. The edge that takes a word-ending beat writes its summary into the
// four-entry queue; the result register takes it from the queue head once it is empty or popped.
// Reset is synchronous and active low and clears the word tracker, the queue pointers and the
// result valid flag. full rises only while the result waits on pop and four words are queued;
// it holds back every text beat, since the beat that ends a word is not known in advance.
module word_token_classifier #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    input  logic        pop,
    output logic        empty,
    output logic [3:0]  o_token_class,
    output logic [15:0] o_word_length
);

    logic                   accept;
    logic                   sum_push;
    wtc_pkg::t_word_summary sum_in;
    wtc_pkg::t_word_summary sum_out;
    logic                   q_empty;
    logic                   q_pop;
    wtc_pkg::t_token_class  token_class;

    // A beat is taken whenever the queue has room, whether or not it ends a word.
    assign accept = push && !full;

    wtc_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (sum_push),
        .o_summary     (sum_in)
    );

    wtc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sum_push),
        .i_data  (sum_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (sum_out),
        .o_empty (q_empty)
    );

    // The back classifies the oldest summary and holds the result until popped.
    wtc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_summary     (sum_out),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_token_class (token_class),
        .o_word_length (o_word_length)
    );

    assign o_token_class = token_class;

endmodule

FILE: bench/word_token_classifier_tb.sv
// Self-checking testbench for the word token classifier: directed and random text streams.
`timescale 1ns / 1ps

module word_token_classifier_tb;

    // A beat that ends a word reaches the result ports through the summary queue and the result
    // register. The end-of-run wait adds margin after the last result is popped.
    localparam int DRAIN_CYCLES  = 8;
    // The receiver may stall for long stretches at its heaviest idle setting, but
    // reaching the stall limit without any accepted beat can only mean a hang.
    localparam int STALL_LIMIT   = 5000;
    localparam int KEYWORD_COUNT = 16;
    localparam int PHASE_BEATS   = 520;

    // The six C whitespace bytes and the double quote.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // One expected result beat.
    typedef struct packed {
        logic [3:0]  cls;
        logic [15:0] len;
    } t_word_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic        full;
    logic [7:0]  i_text_byte   = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        pop           = 1'b0;
    logic        empty;
    logic [3:0]  o_token_class;
    logic [15:0] o_word_length;

    word_token_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .pop           (pop),
        .empty         (empty),
        .o_token_class (o_token_class),
        .o_word_length (o_word_length)
    );

    always #5 i_clk = ~i_clk;

    // Idle percentages of the two sides, changed between phases of the run.
    int send_idle_pct = 36;
    int recv_idle_pct = 80;

    int fail_count    = 0;
    int stall_cycles  = 0;
    int words_checked = 0;
    int beats_sent    = 0;

    // Word tracker of the predictor. The counter is as wide as the length port here,
    // so it saturates at the same value the port does.
    logic                 in_word;
    logic [15:0]          word_len;
    logic [15:0]          kw_alive;
    wtc_pkg::t_num_state  num_state;
    logic [7:0]           first_byte;
    logic [7:0]           last_byte;

    // Token results still owed by the block, oldest first.
    t_word_result pending_tokens[$];

    // Scratch word built by the random generators before it is sent.
    logic [7:0] word_bytes[$];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Keywords in priority order: the first live one of matching length wins.
    function automatic string keyword_spelling(input int k);
        case (k)
            0:       return "int";
            1:       return "float";
            2:       return "double";
            3:       return "char";
            4:       return "string";
            5:       return "bool";
            6:       return "&&";
            7:       return "||";
            8:       return "<";
            9:       return ">";
            10:      return "<=";
            11:      return ">=";
            12:      return "==";
            13:      return "!=";
            14:      return "if";
            default: return "else";
        endcase
    endfunction

    function automatic wtc_pkg::t_token_class keyword_class(input int k);
        if (k <= 5) begin
            return wtc_pkg::TC_TYPE;
        end else if (k <= 7) begin
            return wtc_pkg::TC_LOGICAL;
        end else if (k <= 13) begin
            return wtc_pkg::TC_COMPARISON;
        end else if (k == 14) begin
            return wtc_pkg::TC_IF;
        end
        return wtc_pkg::TC_ELSE;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // Running recognizer for -?D+(.D+)?([eE][+-]?D+)?; anything off the path is dead.
    function automatic wtc_pkg::t_num_state number_step(input wtc_pkg::t_num_state s,
                                                        input logic [7:0] b);
        logic                numeral;
        logic                expo;
        logic                sign;
        wtc_pkg::t_num_state nxt;
        numeral = (b >= "0") && (b <= "9");
        expo    = (b == "e") || (b == "E");
        sign    = (b == "+") || (b == "-");
        nxt     = wtc_pkg::NS_DEAD;
        case (s)
            wtc_pkg::NS_START: begin
                if (b == "-") nxt = wtc_pkg::NS_MINUS;
                else if (numeral) nxt = wtc_pkg::NS_INT;
            end
            wtc_pkg::NS_MINUS: begin
                if (numeral) nxt = wtc_pkg::NS_INT;
            end
            wtc_pkg::NS_INT: begin
                if (numeral) nxt = wtc_pkg::NS_INT;
                else if (b == ".") nxt = wtc_pkg::NS_DOT;
                else if (expo) nxt = wtc_pkg::NS_EXP;
            end
            wtc_pkg::NS_DOT: begin
                if (numeral) nxt = wtc_pkg::NS_FRAC;
            end
            wtc_pkg::NS_FRAC: begin
                if (numeral) nxt = wtc_pkg::NS_FRAC;
                else if (expo) nxt = wtc_pkg::NS_EXP;
            end
            wtc_pkg::NS_EXP: begin
                if (sign) nxt = wtc_pkg::NS_EXPSIGN;
                else if (numeral) nxt = wtc_pkg::NS_EXPDIG;
            end
            wtc_pkg::NS_EXPSIGN, wtc_pkg::NS_EXPDIG: begin
                if (numeral) nxt = wtc_pkg::NS_EXPDIG;
            end
            default: begin
                nxt = wtc_pkg::NS_DEAD;
            end
        endcase
        return nxt;
    endfunction

    function automatic wtc_pkg::t_token_class classify_word();
        string spell;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            spell = keyword_spelling(k);
            if (kw_alive[k] && word_len == spell.len()) return keyword_class(k);
        end
        if (num_state == wtc_pkg::NS_INT || num_state == wtc_pkg::NS_FRAC ||
            num_state == wtc_pkg::NS_EXPDIG)
            return wtc_pkg::TC_NUMBER;
        // Only ASCII letters and underscore open an identifier; bytes of 128 and up never do.
        if ((first_byte >= "A" && first_byte <= "Z") || (first_byte >= "a" && first_byte <= "z")
            || first_byte == "_")
            return wtc_pkg::TC_IDENT;
        // A lone quote is both the first and the last byte, so it counts as a literal.
        if (first_byte == CH_QUOTE && last_byte == CH_QUOTE) return wtc_pkg::TC_LITERAL;
        return wtc_pkg::TC_UNKNOWN;
    endfunction

    task automatic clear_tracker();
        in_word    = 1'b0;
        word_len   = '0;
        kw_alive   = '1;
        num_state  = wtc_pkg::NS_START;
        first_byte = 8'h00;
        last_byte  = 8'h00;
    endtask

    // Advance the tracker by one accepted text beat and queue any result it causes.
    task automatic track_text_beat(input logic [7:0] b, input logic flush);
        t_word_result r;
        string        spell;
        if (flush || is_blank(b)) begin
            // The byte that travels with a flush is ignored, even a non-blank one.
            if (in_word) begin
                r.cls = classify_word();
                r.len = word_len;
                pending_tokens.insert(pending_tokens.size(), r);
            end
            clear_tracker();
        end else begin
            if (!in_word) first_byte = b;
            last_byte = b;
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                spell = keyword_spelling(k);
                if (kw_alive[k]) begin
                    if (word_len >= spell.len()) kw_alive[k] = 1'b0;
                    else if (spell[word_len] != b) kw_alive[k] = 1'b0;
                end
            end
            num_state = number_step(num_state, b);
            if (word_len != 16'hFFFF) word_len = word_len + 16'd1;
            in_word = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Beat monitor: result checking, prediction and the stall watchdog.
    // Everything is sampled at the rising edge, before the block updates.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_monitor
        t_word_result head;
        if (!i_rst_n) begin
            clear_tracker();
        end else begin
            if (pop && !empty) begin
                if (pending_tokens.size() == 0) begin
                    $display("%0t: result beat with nothing expected, class %0d length %0d",
                             $time, o_token_class, o_word_length);
                    fail_count++;
                end else begin
                    head = pending_tokens.pop_front();
                    words_checked++;
                    if (o_token_class !== head.cls) begin
                        $display("%0t: token_class mismatch, expected %0d, actual %0d",
                                 $time, head.cls, o_token_class);
                        fail_count++;
                    end
                    if (o_word_length !== head.len) begin
                        $display("%0t: word_length mismatch, expected %0d, actual %0d",
                                 $time, head.len, o_word_length);
                        fail_count++;
                    end
                end
            end
            if (push && !full) track_text_beat(i_text_byte, i_end_of_text);

            if ((push && !full) || (pop && !empty)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("[word_token_classifier] ERROR");
                $finish;
            end
        end
    end

    // The receiver pops at random, held low during reset.
    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Present one text beat and return at the edge that accepts it. Push is left high
    // so back-to-back beats stream without a bubble; idle cycles drive junk data.
    task automatic send_beat(input logic [7:0] data, input logic flush);
        while ($urandom_range(99) < send_idle_pct) begin
            push          <= 1'b0;
            i_text_byte   <= 8'($urandom);
            i_end_of_text <= 1'($urandom);
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_text_byte   <= data;
        i_end_of_text <= flush;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    endtask

    // Stop sending and wait until every owed result has been popped.
    task automatic wait_for_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_tokens.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random word generators
    // ------------------------------------------------------------------

    task automatic append_byte(input logic [7:0] b);
        word_bytes.insert(word_bytes.size(), b);
    endtask

    function automatic logic [7:0] random_blank();
        int idx;
        idx = $urandom_range(5);
        if (idx == 0) return CH_SPACE;
        return 8'(CH_TAB + idx - 1);
    endfunction

    function automatic logic [7:0] random_nonblank();
        logic [7:0] b;
        b = 8'($urandom);
        while (is_blank(b)) b = 8'($urandom);
        return b;
    endfunction

    function automatic logic [7:0] ident_char();
        case ($urandom_range(3))
            0:       return 8'(8'h61 + $urandom_range(25));
            1:       return 8'(8'h41 + $urandom_range(25));
            2:       return 8'(8'h30 + $urandom_range(9));
            default: return "_";
        endcase
    endfunction

    task automatic append_digits(input int lo, input int hi);
        repeat ($urandom_range(hi, lo)) append_byte(8'(8'h30 + $urandom_range(9)));
    endtask

    // A well-formed signed decimal; minus, fraction and exponent each present half of the time.
    task automatic build_number();
        if ($urandom_range(1)) append_byte("-");
        append_digits(1, 4);
        if ($urandom_range(1)) begin
            append_byte(".");
            append_digits(1, 3);
        end
        if ($urandom_range(1)) begin
            append_byte($urandom_range(1) ? "e" : "E");
            case ($urandom_range(2))
                0:       append_byte("+");
                1:       append_byte("-");
                default: ;
            endcase
            append_digits(1, 3);
        end
    endtask

    task automatic build_random_word();
        string spell;
        int    k;
        int    n;
        word_bytes = {};
        case ($urandom_range(9))
            0, 1: begin
                spell = keyword_spelling($urandom_range(KEYWORD_COUNT - 1));
                for (int i = 0; i < spell.len(); i++) append_byte(spell[i]);
            end
            2: begin
                // Near misses: a keyword cut short or run on by one byte.
                spell = keyword_spelling($urandom_range(KEYWORD_COUNT - 1));
                if (spell.len() > 1 && $urandom_range(1)) begin
                    n = $urandom_range(spell.len() - 1, 1);
                end else begin
                    n = spell.len();
                end
                for (int i = 0; i < n; i++) append_byte(spell[i]);
                if (n == spell.len())
                    append_byte($urandom_range(1) ? ident_char() : random_nonblank());
            end
            3, 4: begin
                build_number();
            end
            5: begin
                // Mostly broken numbers: a well-formed one with a byte added, dropped or prefixed.
                build_number();
                case ($urandom_range(3))
                    0: append_byte(".");
                    1: append_byte($urandom_range(1) ? "e" : "+");
                    2: word_bytes.push_front($urandom_range(1) ? "+" : ".");
                    default: begin
                        if (word_bytes.size() > 1) void'(word_bytes.pop_back());
                        else append_byte("x");
                    end
                endcase
            end
            6: begin
                k = $urandom_range(52);
                if (k < 26) append_byte(8'(8'h61 + k));
                else if (k < 52) append_byte(8'(8'h41 + k - 26));
                else append_byte("_");
                repeat ($urandom_range(7)) append_byte(ident_char());
            end
            7: begin
                // Quoted text, sometimes left open; an empty open one is a lone quote.
                append_byte(CH_QUOTE);
                repeat ($urandom_range(4)) append_byte(random_nonblank());
                if ($urandom_range(1)) append_byte(CH_QUOTE);
            end
            8: begin
                repeat ($urandom_range(6, 1)) append_byte(random_nonblank());
            end
            default: begin
                append_byte(random_nonblank());
                repeat ($urandom_range(5)) append_byte(ident_char());
            end
        endcase
    endtask

    // End a word by whitespace or by a flush; extra beats land outside any word.
    task automatic send_separator();
        case ($urandom_range(9))
            0, 1: send_beat(8'($urandom), 1'b1);
            2: begin
                send_beat(random_blank(), 1'b0);
                send_beat(8'($urandom), 1'b1);
            end
            default: repeat ($urandom_range(3, 1)) send_beat(random_blank(), 1'b0);
        endcase
    endtask

    task automatic run_random_phase(input int s_pct, input int r_pct, input int beat_goal);
        int start;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = beats_sent;
        while (beats_sent - start < beat_goal) begin
            build_random_word();
            foreach (word_bytes[i]) send_beat(word_bytes[i], 1'b0);
            send_separator();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One word per keyword family, each ended by a different whitespace byte or a flush.
    task automatic test_keyword_words();
        send_text("int");
        send_beat(CH_SPACE, 1'b0);
        send_text("&&");
        send_beat(CH_TAB, 1'b0);
        send_text("<=");
        send_beat(CH_LF, 1'b0);
        send_text("if");
        send_beat(CH_VT, 1'b0);
        send_text("else");
        send_beat(8'h00, 1'b1);
    endtask

    // Full signed form, a bare digit, and a number that stops on its dot.
    task automatic test_number_words();
        send_text("-1.5e+3");
        send_beat(CH_CR, 1'b0);
        send_text("7");
        send_beat(CH_FF, 1'b0);
        send_text("1.");
        send_beat(CH_SPACE, 1'b0);
    endtask

    task automatic test_edge_bytes();
        // Whitespace outside a word and a flush with no word pending: no results.
        send_beat(CH_SPACE, 1'b0);
        send_beat(8'hFF, 1'b1);
        // High bytes are never letters; NUL is an ordinary word byte.
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(CH_SPACE, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(CH_TAB, 1'b0);
        // A lone quote is a literal.
        send_beat(CH_QUOTE, 1'b0);
        send_beat(CH_SPACE, 1'b0);
        // The letter that rides with a flush must not join the word.
        send_beat("q", 1'b0);
        send_beat("r", 1'b1);
    endtask

    // Words far longer than any keyword: a long number and a long identifier.
    task automatic test_long_words();
        repeat (100) send_beat("7", 1'b0);
        send_beat(8'h00, 1'b1);
        repeat (120) send_beat("a", 1'b0);
        send_beat(CH_SPACE, 1'b0);
        wait_for_results();
    endtask

    // Three idling mixes; the sender holds off until the block is drained in between.
    task automatic test_random_text();
        run_random_phase(36, 80, PHASE_BEATS);
        wait_for_results();
        run_random_phase(80, 36, PHASE_BEATS);
        wait_for_results();
        run_random_phase(0, 0, PHASE_BEATS);
        // Close whatever word the last phase left open.
        send_beat(8'h00, 1'b1);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_keyword_words();
        test_number_words();
        test_edge_bytes();
        test_long_words();
        test_random_text();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d text beats: keywords, numbers, literals, odd bytes and two", beats_sent);
        $display("long words, under three idling mixes; %0d words checked.", words_checked);
        if (fail_count == 0) begin
            $display("[word_token_classifier] OK");
        end else begin
            $display("[word_token_classifier] ERROR");
        end
        $finish;
    end

endmodule
